[rtl/fprt_pkg.sv]
// Package: widths, result kinds and shared types of the frame part reassembly tracker.
`default_nettype none

package fprt_pkg;

  localparam int INDEX_BITS = 31;
  localparam int SIZE_BITS  = 24;
  localparam int PSIZE_BITS = 16;
  localparam int KIND_BITS  = 2;
  localparam int MAX_RES    = 3;

  localparam logic [KIND_BITS-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_CLOSE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_DROP  = 2'd2;

  localparam logic [INDEX_BITS-1:0] IDX_ONE = {{(INDEX_BITS-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic                  parse_ok;
    logic [INDEX_BITS-1:0] frame_num;
    logic [SIZE_BITS-1:0]  byte_offset;
    logic [PSIZE_BITS-1:0] part_size;
    logic [SIZE_BITS-1:0]  total_size;
  } pkt_t;

  // cur_vld / lf_vld low stand for an index of minus one
  typedef struct packed {
    logic                  cur_vld;
    logic [INDEX_BITS-1:0] cur_idx;
    logic                  lf_vld;
    logic [INDEX_BITS-1:0] lf_idx;
    logic [SIZE_BITS-1:0]  exp_off;
    logic                  open;
    logic [INDEX_BITS-1:0] open_idx;
    logic [SIZE_BITS-1:0]  open_tot;
  } state_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [INDEX_BITS-1:0] report_index;
    logic [SIZE_BITS-1:0]  ack_offset;
    logic [SIZE_BITS-1:0]  expected_bytes;
    logic [SIZE_BITS-1:0]  received_bytes;
    logic                  frame_complete;
    logic [INDEX_BITS-1:0] skipped_frames;
    logic                  accepted;
    logic                  invalid;
    logic                  last;
  } res_t;

  // Part size resized to the offset width (zero extend or truncate).
  function automatic logic [SIZE_BITS-1:0] fit_size(input logic [PSIZE_BITS-1:0] psz);
    logic [SIZE_BITS+PSIZE_BITS-1:0] ext;
    ext = {{SIZE_BITS{1'b0}}, psz};
    return ext[SIZE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/fprt_pkt_if.sv]
// Interfaces: packet header channel and result channel.
`default_nettype none

interface fprt_pkt_if import fprt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  parse_ok;
  logic [INDEX_BITS-1:0] frame_num;
  logic [SIZE_BITS-1:0]  byte_offset;
  logic [PSIZE_BITS-1:0] part_size;
  logic [SIZE_BITS-1:0]  total_size;

  modport source (output valid, parse_ok, frame_num, byte_offset, part_size, total_size,
                  input ready);
  modport sink   (input valid, parse_ok, frame_num, byte_offset, part_size, total_size,
                  output ready);
endinterface

interface fprt_res_if import fprt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  kind;
  logic [INDEX_BITS-1:0] report_index;
  logic [SIZE_BITS-1:0]  ack_offset;
  logic [SIZE_BITS-1:0]  expected_bytes;
  logic [SIZE_BITS-1:0]  received_bytes;
  logic                  frame_complete;
  logic [INDEX_BITS-1:0] skipped_frames;
  logic                  accepted;
  logic                  invalid;
  logic                  last;

  modport source (output valid, kind, report_index, ack_offset, expected_bytes,
                  received_bytes, frame_complete, skipped_frames, accepted, invalid, last,
                  input ready);
  modport sink   (input valid, kind, report_index, ack_offset, expected_bytes,
                  received_bytes, frame_complete, skipped_frames, accepted, invalid, last,
                  output ready);
endinterface

`default_nettype wire

[rtl/fprt_decide.sv]
// Decision logic: results and next tracker state for one packet header.
`default_nettype none

module fprt_decide import fprt_pkg::*; (
  input  pkt_t                 pkt_i,
  input  state_t               st_i,
  output res_t [MAX_RES-1:0]   res_o,
  output logic [1:0]           n_o,
  output state_t               st_o
);

  logic                  jump, dup;
  logic                  close1, close2, fo1, acc;
  logic [SIZE_BITS-1:0]  eo1, eo2;
  logic [INDEX_BITS-1:0] skipped;
  state_t                st_mid;
  res_t                  rep1, ack, rep2;

  assign jump = !st_i.cur_vld || (pkt_i.frame_num > st_i.cur_idx);
  assign dup  = !jump && st_i.lf_vld && (pkt_i.frame_num <= st_i.lf_idx);

  always_comb begin
    st_mid  = st_i;
    close1  = 1'b0;
    fo1     = st_i.open;
    eo1     = st_i.exp_off;
    skipped = '0;
    rep1    = '0;

    // a higher index closes the open frame first and restarts the offset
    if (jump) begin
      close1              = st_i.open;
      rep1.kind           = KIND_CLOSE;
      rep1.report_index   = st_i.open_idx;
      rep1.expected_bytes = st_i.open_tot;
      rep1.received_bytes = st_i.exp_off;
      rep1.frame_complete = (st_i.exp_off == st_i.open_tot);
      if (st_i.open) begin
        st_mid.lf_vld = 1'b1;
        st_mid.lf_idx = st_i.open_idx;
      end
      st_mid.open    = 1'b0;
      st_mid.cur_vld = 1'b1;
      st_mid.cur_idx = pkt_i.frame_num;
      st_mid.exp_off = '0;
      fo1            = 1'b0;
      eo1            = '0;
      skipped        = st_i.cur_vld ? (pkt_i.frame_num - st_i.cur_idx - IDX_ONE)
                                    : pkt_i.frame_num;
    end
  end

  always_comb begin
    st_o   = st_mid;
    acc    = 1'b0;
    eo2    = eo1;
    close2 = 1'b0;
    ack    = '0;
    rep2   = '0;

    if (!fo1) begin
      if (pkt_i.byte_offset == '0) begin
        st_o.open     = 1'b1;
        st_o.open_idx = pkt_i.frame_num;
        st_o.open_tot = pkt_i.total_size;
        eo2           = fit_size(pkt_i.part_size);
        acc           = 1'b1;
      end
    end else if (pkt_i.byte_offset == eo1) begin
      eo2 = eo1 + fit_size(pkt_i.part_size);
      acc = 1'b1;
    end
    st_o.exp_off = eo2;

    ack.kind         = KIND_ACK;
    ack.report_index = pkt_i.frame_num;
    ack.ack_offset   = eo2;

    // the size check uses this part's declared total, the report the frame's own
    rep2.kind           = KIND_CLOSE;
    rep2.report_index   = st_o.open_idx;
    rep2.expected_bytes = st_o.open_tot;
    rep2.received_bytes = eo2;
    rep2.frame_complete = (eo2 == st_o.open_tot);
    if (st_o.open && (eo2 == pkt_i.total_size)) begin
      close2      = 1'b1;
      st_o.open   = 1'b0;
      st_o.lf_vld = 1'b1;
      st_o.lf_idx = st_o.open_idx;
    end

    res_o = '0;
    n_o   = 2'd1;
    priority if (!pkt_i.parse_ok) begin
      st_o            = st_i;
      res_o[0].kind   = KIND_DROP;
      res_o[0].invalid = 1'b1;
      res_o[0].last   = 1'b1;
    end else if (dup) begin
      st_o                 = st_i;
      res_o[0].kind        = KIND_DROP;
      res_o[0].report_index = pkt_i.frame_num;
      res_o[0].last        = 1'b1;
    end else begin
      if (close1) begin
        res_o[0] = rep1;
        res_o[1] = ack;
        res_o[2] = rep2;
      end else begin
        res_o[0] = ack;
        res_o[1] = rep2;
      end
      n_o = 2'd1 + {1'b0, close1} + {1'b0, close2};
      for (int k = 0; k < MAX_RES; k++) begin
        res_o[k].skipped_frames = skipped;
        res_o[k].accepted       = acc;
        res_o[k].last           = (n_o == 2'(k + 1));
      end
    end
  end

endmodule

`default_nettype wire

[rtl/fprt_res_q.sv]
// Result queue: holds up to three results of one packet and shifts them out in order.
`default_nettype none

module fprt_res_q import fprt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [1:0]         n_i,
  input  res_t [MAX_RES-1:0] res_i,
  input  logic               pop_i,
  output res_t               head_o,
  output logic               valid_o,
  output logic               free_o
);

  logic [1:0]         cnt_q, cnt_d;
  res_t [MAX_RES-1:0] slot_q;

  assign head_o  = slot_q[0];
  assign valid_o = (cnt_q != 2'd0);
  // empty now, or the last held result leaves at this edge
  assign free_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_i);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = n_i;
    end else if (pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= res_i;
    end else if (pop_i) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

endmodule

`default_nettype wire

[rtl/frame_part_reassembly_tracker_core.sv]
// Top level: frame part reassembly tracker with input register, decision stage, result queue.
// Path: input register, then decision stage, then result queue; a header waits in the input
//   register while the queue is not free. Throughput: one header per cycle while each header
//   yields one result and res_o is ready; a header with n results (up to three) holds the
//   decision stage while they leave the result queue, one result per cycle while res_o is ready.
// Reset: asynchronous, active low; clears tracker state (no frame open, no index seen,
//   offset zero), the input register and the result queue. No clearing pass.
`default_nettype none

module frame_part_reassembly_tracker_core import fprt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fprt_pkt_if.sink    pkt_i,
  fprt_res_if.source  res_o
);

  // input register
  logic               in_vld_q;
  pkt_t               in_q;
  pkt_t               in_d;

  // tracker state
  state_t             st_q, st_d;

  // decision stage
  res_t [MAX_RES-1:0] dec_res;
  logic [1:0]         dec_n;
  logic               q_free, fire, pop;
  res_t               head;

  assign in_d = '{parse_ok:    pkt_i.parse_ok,
                  frame_num:   pkt_i.frame_num,
                  byte_offset: pkt_i.byte_offset,
                  part_size:   pkt_i.part_size,
                  total_size:  pkt_i.total_size};

  // Advance a header into the decision stage only when the queue can take all its results.
  assign pop         = res_o.valid && res_o.ready;
  assign fire        = in_vld_q && q_free;
  assign pkt_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (pkt_i.ready) begin
      in_vld_q <= pkt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_i.valid && pkt_i.ready) begin
      in_q <= in_d;
    end
  end

  fprt_decide u_decide (
    .pkt_i (in_q),
    .st_i  (st_q),
    .res_o (dec_res),
    .n_o   (dec_n),
    .st_o  (st_d)
  );

  // Commit the state update together with the results of the same header.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  fprt_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .n_i     (dec_n),
    .res_i   (dec_res),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (res_o.valid),
    .free_o  (q_free)
  );

  assign res_o.kind           = head.kind;
  assign res_o.report_index   = head.report_index;
  assign res_o.ack_offset     = head.ack_offset;
  assign res_o.expected_bytes = head.expected_bytes;
  assign res_o.received_bytes = head.received_bytes;
  assign res_o.frame_complete = head.frame_complete;
  assign res_o.skipped_frames = head.skipped_frames;
  assign res_o.accepted       = head.accepted;
  assign res_o.invalid        = head.invalid;
  assign res_o.last           = head.last;

  // A header in the decision stage always produces at least one result.
  a_nonzero_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> (dec_n != 2'd0))
    else $error("decision stage produced no result");

  // Results of a loaded header are offered in the next cycle.
  a_fire_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_o.valid)
    else $error("loaded results not offered");

  // A transfer that is not the last of its header leaves more results behind.
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !res_o.last) |=> res_o.valid)
    else $error("results lost after a non-final transfer");

  // An open frame implies an index has been seen.
  a_open_has_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.open |-> st_q.cur_vld)
    else $error("frame open without a current index");

  // The last finished frame never lies above the current index.
  a_finished_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.lf_vld |-> (st_q.cur_vld && (st_q.lf_idx <= st_q.cur_idx)))
    else $error("finished index above current index");

endmodule

`default_nettype wire
